/* rtl/rhc_pkg.sv */
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants of the RGB to HSV converter
// Pixel and result request layouts, the divider lane and the record that
// travels down the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

  // channel and result widths
  localparam int CHAN_W  = 8;
  localparam int HUE_W   = 9;
  // quotient bits produced by the chain, one per cell
  localparam int Q_W     = HUE_W;
  localparam int N_CELLS = Q_W;
  // dividend width: initial partial remainder plus the bits shifted in
  localparam int DVD_W   = CHAN_W + Q_W;
  // signed working width for the hue numerator
  localparam int NUM_SW  = DVD_W + 2;

  // hue constants in degrees
  localparam int HUE_SECTOR = 60;
  localparam int HUE_GREEN  = 120;
  localparam int HUE_BLUE   = 240;
  localparam int HUE_FULL   = 360;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] value;
  } pix_out_t;

  // which channel is largest
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // one restoring divider lane: partial remainder, dividend bits still to
  // come (shifting out at the top) with quotient bits entering at the bottom
  typedef struct packed {
    logic [CHAN_W-1:0] rem;
    logic [Q_W-1:0]    bits;
    logic [CHAN_W-1:0] dsr;
  } lane_t;

  typedef struct packed {
    logic              vld;
    logic              grey;
    logic [CHAN_W-1:0] value;
    lane_t             hue_ln;
    lane_t             sat_ln;
  } stage_t;

endpackage

`default_nettype wire

/* rtl/rgb_to_hsv_converter.sv */
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter: pipelined RGB to HSV pixel converter
// Front stage, a chain of restoring divider cells and an output register.
//
//   channel  ports                       payload
//   in       in_valid  in_stall  in_data   pix_in_t  (red, green, blue)
//   out      out_valid out_stall out_data  pix_out_t (hue, saturation, value)
//
// One pixel per clock while no result is held under out_stall; front stage, nine
// divider cells (one quotient bit each, hue and saturation in parallel),
// output register.
// Reset (rst_n low, synchronous) clears all stage valid flags.
// A held result under out_stall freezes the whole chain and raises in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_converter
  import rhc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  var  pix_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output pix_out_t      out_data
);

  logic     adv;
  stage_t   chain [0:N_CELLS];
  stage_t   last;
  logic     out_valid_r;
  pix_out_t out_data_r, out_data_nxt;

  // chain moves whenever the output slot is free or being taken
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  rhc_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_vld    (in_valid),
    .pix       (in_data),
    .stage_out (chain[0])
  );

  // divider cells
  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    rhc_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .stage_in  (chain[i]),
      .stage_out (chain[i+1])
    );
  end

  assign last = chain[N_CELLS];

  // result format; grey pixels give zero hue and saturation
  always_comb begin
    out_data_nxt.value = last.value;
    if (last.grey) begin
      out_data_nxt.hue        = '0;
      out_data_nxt.saturation = '0;
    end else begin
      out_data_nxt.hue        = last.hue_ln.bits;
      out_data_nxt.saturation = last.sat_ln.bits[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= last.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  a_last_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last.vld) |=> out_valid)
    else $error("finished request lost at output register");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !last.vld) |=> !out_valid)
    else $error("result repeated after hand-over");

  a_sat_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (last.vld && !last.grey) |-> (last.sat_ln.bits[Q_W-1] == 1'b0))
    else $error("saturation quotient overflow");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    (last.vld && !last.grey) |-> (last.hue_ln.bits < HUE_W'(HUE_FULL)))
    else $error("hue quotient out of range");

endmodule

`default_nettype wire

/* rtl/rhc_prep.sv */
// ----------------------------------------------------------------------------
// rhc_prep: front stage of the RGB to HSV converter
// Finds max and min, picks the hue sector and loads both divider lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_prep
  import rhc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    adv,
  input  wire logic    in_vld,
  input  var  pix_in_t pix,
  output var  stage_t  stage_out
);

  localparam logic signed [NUM_SW-1:0] K_SEC   = NUM_SW'(HUE_SECTOR);
  localparam logic signed [NUM_SW-1:0] K_GREEN = NUM_SW'(HUE_GREEN);
  localparam logic signed [NUM_SW-1:0] K_BLUE  = NUM_SW'(HUE_BLUE);
  localparam logic signed [NUM_SW-1:0] K_FULL  = NUM_SW'(HUE_FULL);

  logic [CHAN_W-1:0]        mx, mn, delta;
  sector_t                  sec;
  logic signed [NUM_SW-1:0] rs, gs, bs, ds, num;
  logic [DVD_W-1:0]         sat_dvd, hue_dvd;
  stage_t                   stage_nxt, stage_r;

  // max, min and sector; ties go red, then green
  always_comb begin
    if (pix.red >= pix.green && pix.red >= pix.blue) begin
      sec = SEC_RED;
      mx  = pix.red;
    end else if (pix.green >= pix.blue) begin
      sec = SEC_GREEN;
      mx  = pix.green;
    end else begin
      sec = SEC_BLUE;
      mx  = pix.blue;
    end
    if (pix.red <= pix.green && pix.red <= pix.blue) mn = pix.red;
    else if (pix.green <= pix.blue)                 mn = pix.green;
    else                                            mn = pix.blue;
    delta = mx - mn;
  end

  // hue numerator, always in [0, 360*delta)
  always_comb begin
    rs = $signed({{(NUM_SW-CHAN_W){1'b0}}, pix.red});
    gs = $signed({{(NUM_SW-CHAN_W){1'b0}}, pix.green});
    bs = $signed({{(NUM_SW-CHAN_W){1'b0}}, pix.blue});
    ds = $signed({{(NUM_SW-CHAN_W){1'b0}}, delta});
    case (sec)
      SEC_RED: begin
        num = K_SEC * (gs - bs);
        if (num < 0) num = num + K_FULL * ds;
      end
      SEC_GREEN: num = K_GREEN * ds + K_SEC * (bs - rs);
      SEC_BLUE:  num = K_BLUE * ds + K_SEC * (rs - gs);
      default:   num = '0;
    endcase
  end

  // load the lanes: saturation dividend is delta * full scale
  always_comb begin
    sat_dvd = DVD_W'({delta, {CHAN_W{1'b0}}}) - DVD_W'(delta);
    hue_dvd = num[DVD_W-1:0];
    stage_nxt.vld         = in_vld;
    stage_nxt.grey        = (delta == '0);
    stage_nxt.value       = mx;
    stage_nxt.hue_ln.rem  = hue_dvd[DVD_W-1:Q_W];
    stage_nxt.hue_ln.bits = hue_dvd[Q_W-1:0];
    stage_nxt.hue_ln.dsr  = delta;
    stage_nxt.sat_ln.rem  = sat_dvd[DVD_W-1:Q_W];
    stage_nxt.sat_ln.bits = sat_dvd[Q_W-1:0];
    stage_nxt.sat_ln.dsr  = mx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.vld <= 1'b0;
    end else if (adv) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_out = stage_r;

endmodule

`default_nettype wire

/* rtl/rhc_div_cell.sv */
// ----------------------------------------------------------------------------
// rhc_div_cell: one cell of the divider chain
// Produces one quotient bit of the hue and of the saturation lane.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_div_cell
  import rhc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   adv,
  input  var  stage_t stage_in,
  output var  stage_t stage_out
);

  stage_t stage_nxt, stage_r;

  // restoring step: shift in next dividend bit, subtract if it fits
  function automatic lane_t div_step(input lane_t ln);
    logic [CHAN_W:0] t;
    lane_t           o;
    t      = {ln.rem, ln.bits[Q_W-1]};
    o      = ln;
    o.bits = {ln.bits[Q_W-2:0], 1'b0};
    if (t >= {1'b0, ln.dsr}) begin
      o.rem     = CHAN_W'(t - {1'b0, ln.dsr});
      o.bits[0] = 1'b1;
    end else begin
      o.rem = t[CHAN_W-1:0];
    end
    return o;
  endfunction

  always_comb begin
    stage_nxt        = stage_in;
    stage_nxt.hue_ln = div_step(stage_in.hue_ln);
    stage_nxt.sat_ln = div_step(stage_in.sat_ln);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.vld <= 1'b0;
    end else if (adv) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_out = stage_r;

endmodule

`default_nettype wire

/* test/rgb_to_hsv_converter_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_checker: result checker for the RGB to HSV converter
// Watches both request channels, works out the HSV value of every accepted
// pixel and compares each returned result with the oldest one outstanding.
// ----------------------------------------------------------------------------

module rgb_to_hsv_converter_checker
  import rhc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  pix_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  pix_out_t out_data,
  output int       fail_count,
  output int       pending
);

  localparam int FULL_SCALE = (1 << CHAN_W) - 1;
  localparam int SHOW_LIMIT = 10;

  pix_out_t hsv_expected [$];
  int       mismatch_count = 0;

  // integer HSV of one pixel; ties go red, then green, then blue
  function automatic pix_out_t hsv_of(input pix_in_t px);
    pix_out_t res;
    int r, g, b, mx, mn, delta, num;
    r = px.red;
    g = px.green;
    b = px.blue;
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    delta = mx - mn;
    res = '0;
    res.value = mx[CHAN_W-1:0];
    if (mx != 0) begin
      res.saturation = CHAN_W'((delta * FULL_SCALE) / mx);
    end
    if (delta != 0) begin
      if (r == mx) begin
        num = HUE_SECTOR * (g - b);
        if (num < 0) begin
          num = num + HUE_FULL * delta;
        end
      end else if (g == mx) begin
        num = HUE_GREEN * delta + HUE_SECTOR * (b - r);
      end else begin
        num = HUE_BLUE * delta + HUE_SECTOR * (r - g);
      end
      res.hue = HUE_W'(num / delta);
    end
    return res;
  endfunction

  // results are compared first, then the new pixel is queued
  always @(posedge clk) begin
    pix_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (hsv_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= SHOW_LIMIT) begin
            $display("%0t: unexpected result hue %0d sat %0d val %0d", $time,
                     out_data.hue, out_data.saturation, out_data.value);
          end
        end else begin
          want = hsv_expected.pop_front();
          if (out_data.hue !== want.hue || out_data.saturation !== want.saturation ||
              out_data.value !== want.value) begin
            mismatch_count++;
            if (mismatch_count <= SHOW_LIMIT) begin
              $display("%0t: mismatch exp h/s/v %0d/%0d/%0d got %0d/%0d/%0d", $time,
                       want.hue, want.saturation, want.value,
                       out_data.hue, out_data.saturation, out_data.value);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        hsv_expected.push_back(hsv_of(in_data));
      end
    end
    fail_count <= mismatch_count;
    pending <= hsv_expected.size();
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the RGB to HSV converter
// Sends directed corner pixels then a long random mix of pixels with random
// gaps and back-pressure, one long receiver hold included, and reports the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------

module tb;
  import rhc_pkg::*;

  localparam int N_RANDOM     = 1400;
  localparam int QUIET_FROM   = N_RANDOM * 9 / 10;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 30;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int N_DIRECTED   = 21;

  // corner pixels, packed as red, green, blue
  localparam logic [23:0] CORNER_PIXELS [N_DIRECTED] = '{
    24'h000000,  // black
    24'hFFFFFF,  // white
    24'h808080,  // mid grey
    24'h010101,  // dark grey
    24'hFF0000,  // pure red
    24'h00FF00,  // pure green
    24'h0000FF,  // pure blue
    24'hFFFF00,  // red and green tie
    24'h00FFFF,  // green and blue tie
    24'hFF00FF,  // red and blue tie
    24'hFF0001,  // hue just under a full turn
    24'hFF0100,  // hue just over zero
    24'h01FF00,  // green sector, low side
    24'h0001FF,  // blue sector, low side
    24'h010000,  // smallest lit pixel
    24'h000001,
    24'hFEFFFF,  // smallest delta at full value
    24'hFFFEFE,
    24'h7F8081,  // bit flips around mid scale
    24'hAA55CC,
    24'h55AA33
  };

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  pix_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  pix_out_t out_data;
  int       fail_count;
  int       pending;
  int       cycles = 0;
  int       free_run = 0;
  bit       quiet = 1'b0;

  always #1 clk = ~clk;

  rgb_to_hsv_converter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  rgb_to_hsv_converter_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // offer one pixel, hold it until taken, then maybe leave a gap
  task automatic offer_pixel(input pix_in_t px);
    in_data <= px;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (quiet) begin
      free_run = 0;
    end else if (free_run > 0) begin
      free_run--;
    end else if ($urandom_range(0, 19) == 0) begin
      free_run = $urandom_range(30, 100);
    end else if ($urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // random pixel drawn from a mix of shapes that hit the awkward cases
  function automatic pix_in_t random_pixel();
    pix_in_t px;
    logic [7:0] lvl;
    px = pix_in_t'($urandom);
    lvl = 8'($urandom);
    case ($urandom_range(0, 9))
      5: px = '{red: lvl, green: lvl, blue: lvl};  // grey
      6: begin  // two channels set equal
        case ($urandom_range(0, 2))
          0: px.green = px.red;
          1: px.blue = px.green;
          default: px.blue = px.red;
        endcase
      end
      7: px = '{red: 8'($urandom_range(0, 3)), green: 8'($urandom_range(0, 3)),
                blue: 8'($urandom_range(0, 3))};
      8: px = '{red: ($urandom_range(0, 1) ? 8'hFF : 8'h00) ^ 8'($urandom_range(0, 1)),
                green: ($urandom_range(0, 1) ? 8'hFF : 8'h00) ^ 8'($urandom_range(0, 1)),
                blue: ($urandom_range(0, 1) ? 8'hFF : 8'h00) ^ 8'($urandom_range(0, 1))};
      9: px.red = 8'($urandom_range(250, 255));
      default: ;
    endcase
    return px;
  endfunction

  // stimulus and verdict
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < N_DIRECTED; i++) begin
      offer_pixel(pix_in_t'(CORNER_PIXELS[i]));
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == QUIET_FROM) quiet = 1'b1;
      offer_pixel(random_pixel());
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("rgb_to_hsv_converter test passed");
    end else begin
      $display("rgb_to_hsv_converter test failed");
    end
    $finish;
  end

  // receiver back-pressure: random stall bursts, one long hold, calm at the end
  initial begin
    int rx_cycles;
    int calm_left;
    rx_cycles = 0;
    calm_left = 0;
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (quiet) begin
        out_stall <= 1'b0;
      end else if (rx_cycles == HOLD_AT) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(20, 80);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("rgb_to_hsv_converter test failed");
      $finish;
    end
  end

endmodule

/* sim.f */
rtl/rhc_pkg.sv
rtl/rhc_prep.sv
rtl/rhc_div_cell.sv
rtl/rgb_to_hsv_converter.sv
test/rgb_to_hsv_converter_checker.sv
test/tb.sv
